// ----- design/sequence_replay_window_macros.svh -----
// assertion macros for the sequence replay window
// expects clk and rst in scope at the point of use
`ifndef SEQUENCE_REPLAY_WINDOW_MACROS_SVH
`define SEQUENCE_REPLAY_WINDOW_MACROS_SVH

// same-cycle implication
`define SRW_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sequence_replay_window: check failed");

// next-cycle implication
`define SRW_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sequence_replay_window: check failed");

`endif

// ----- design/srw_pkg.sv -----
// types and constants for the sequence replay window
// no dependencies
`timescale 1ns / 1ps

package srw_pkg;

  localparam int unsigned LATE_WINDOW_DEFAULT = 4;
  localparam int unsigned SEQ_W = 16;
  localparam int unsigned POS_W = 32;
  localparam int unsigned LIMIT_W = 15;
  localparam logic [LIMIT_W-1:0] FORWARD_LIMIT_RESET = 15'd8;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LATE   = 3'd1,
    ST_DUP    = 3'd2,
    ST_NOTFWD = 3'd3,
    ST_BEHIND = 3'd4
  } status_t;

  typedef struct packed {
    logic [SEQ_W-1:0]        sequence_req;
    logic                    queue_empty;
    logic                    output_silent;
    logic                    playout_valid;
    logic signed [POS_W-1:0] next_playout_position;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic                    reanchored;
    logic signed [POS_W-1:0] extended_position;
  } res_t;

endpackage

// ----- design/sequence_replay_window.sv -----
// sequence replay window: anti-replay window and playout admission check
// depends on srw_pkg and sequence_replay_window_macros.svh
//
// usage
//   request channel: req_valid / req_stall / req_data (req_t). a request is
//   taken at a rising edge with req_valid high and req_stall low.
//   result channel: res_valid / res_stall / res_data (res_t), one result per
//   request, in request order.
//   cfg_write with cfg_data sets forward_limit; write only while idle.
//   a taken request waits in the request register; its result loads into
//   the result register when it advances. throughput: one request per cycle
//   unless the result stalls. the request register feeds the window logic
//   (33-bit adds/subtracts, compares, a small bitmap shift); window state and
//   result register load in the same cycle; the next request sees the update.
//   reset: window unanchored, bitmap clear, forward_limit back to 8, both
//   pipeline registers empty.
//   stall: a held result keeps the request register full; req_stall rises
//   only when the request register cannot move on, so one request is held
//   inside while the result waits.
`timescale 1ns / 1ps
`include "sequence_replay_window_macros.svh"

module sequence_replay_window
  import srw_pkg::*;
#(
  parameter int unsigned LATE_WINDOW = LATE_WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res_data,
  input  logic               cfg_write,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int unsigned BM_W = LATE_WINDOW + 1;
  localparam int unsigned IW = $clog2(BM_W);
  localparam logic [POS_W-1:0] LW_POS = POS_W'(LATE_WINDOW);
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // configuration and window state
  logic [LIMIT_W-1:0]      forward_limit;
  logic                    anchored;
  logic [SEQ_W-1:0]        newest_sequence;
  logic signed [POS_W-1:0] newest_position;
  logic [BM_W-1:0]         seen_bitmap;

  // pipeline registers
  logic req_full;
  req_t req_reg;
  logic advance;

  // window logic
  logic [SEQ_W-1:0]        d;
  logic signed [POS_W:0]   ext_wide;
  logic signed [POS_W-1:0] ext;
  logic [POS_W:0]          off;
  logic [POS_W:0]          neg_off;
  logic                    reanchor_req;
  logic                    fwd_jump;
  logic                    do_anchor;
  logic                    do_advance_newest;
  logic                    do_mark;
  logic                    reanch;
  status_t                 status;
  logic signed [POS_W-1:0] ext_out;
  logic                    anchored_next;
  logic [SEQ_W-1:0]        newest_sequence_next;
  logic signed [POS_W-1:0] newest_position_next;
  logic [BM_W-1:0]         seen_bitmap_next;
  res_t                    res_next;

  assign advance   = req_full && (!res_valid || !res_stall);
  assign req_stall = req_full && !advance;

  always_comb begin
    d = req_reg.sequence_req - newest_sequence;
    ext_wide = {newest_position[POS_W-1], newest_position}
             + {{(POS_W+1-SEQ_W){d[SEQ_W-1]}}, d};
    unique case (ext_wide[POS_W:POS_W-1])
      2'b01:   ext = POS_MAX;
      2'b10:   ext = POS_MIN;
      default: ext = ext_wide[POS_W-1:0];
    endcase
    off = {newest_position[POS_W-1], newest_position} - {ext[POS_W-1], ext};
    neg_off = (POS_W+1)'(0) - off;
    reanchor_req = req_reg.queue_empty && req_reg.output_silent;
    fwd_jump = !d[SEQ_W-1] && (d[SEQ_W-2:0] > forward_limit);

    status = ST_OK;
    reanch = 1'b0;
    ext_out = ext;
    do_anchor = 1'b0;
    do_advance_newest = 1'b0;
    do_mark = 1'b0;

    if (!anchored) begin
      do_anchor = 1'b1;
      ext_out = '0;
    end else if (fwd_jump) begin
      do_anchor = 1'b1;
      reanch = 1'b1;
      ext_out = '0;
    end else if (!off[POS_W] && (off[POS_W-1:0] > LW_POS)) begin
      status = ST_LATE;
    end else if (!off[POS_W] && seen_bitmap[off[IW-1:0]]) begin
      status = ST_DUP;
    end else if (reanchor_req) begin
      if (d[SEQ_W-1] || (d == '0)) begin
        status = ST_NOTFWD;
      end else begin
        do_anchor = 1'b1;
        reanch = 1'b1;
        ext_out = '0;
      end
    end else if (off[POS_W]) begin
      do_advance_newest = 1'b1;
    end else begin
      do_mark = 1'b1;
    end

    anchored_next = anchored;
    newest_sequence_next = newest_sequence;
    newest_position_next = newest_position;
    seen_bitmap_next = seen_bitmap;
    if (do_anchor) begin
      anchored_next = 1'b1;
      newest_sequence_next = req_reg.sequence_req;
      newest_position_next = '0;
      seen_bitmap_next = BM_W'(1);
    end else if (do_advance_newest) begin
      newest_sequence_next = req_reg.sequence_req;
      newest_position_next = ext;
      // a step past the whole window leaves only the new position marked
      if (neg_off[POS_W-1:0] > LW_POS) begin
        seen_bitmap_next = BM_W'(1);
      end else begin
        seen_bitmap_next = (seen_bitmap << neg_off[IW-1:0]) | BM_W'(1);
      end
    end else if (do_mark) begin
      seen_bitmap_next = seen_bitmap | (BM_W'(1) << off[IW-1:0]);
    end

    // playout check comes after the window update
    if ((status == ST_OK) && !reanch && req_reg.playout_valid
        && (ext_out < req_reg.next_playout_position)) begin
      status = ST_BEHIND;
    end
    if (status != ST_OK) begin
      reanch = 1'b0;
      ext_out = '0;
    end

    res_next.status = status;
    res_next.reanchored = reanch;
    res_next.extended_position = ext_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_limit   <= FORWARD_LIMIT_RESET;
      anchored        <= 1'b0;
      newest_sequence <= '0;
      newest_position <= '0;
      seen_bitmap     <= '0;
      req_full        <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        forward_limit <= cfg_data;
      end
      if (req_valid && !req_stall) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        res_valid       <= 1'b1;
        anchored        <= anchored_next;
        newest_sequence <= newest_sequence_next;
        newest_position <= newest_position_next;
        seen_bitmap     <= seen_bitmap_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_reg <= req_data;
    end
    if (advance) begin
      res_data <= res_next;
    end
  end

  `SRW_ASSERT_IMP(a_reject_clean, res_valid && (res_data.status != ST_OK),
    !res_data.reanchored && (res_data.extended_position == '0))
  `SRW_ASSERT_IMP(a_reanchor_zero, res_valid && res_data.reanchored,
    res_data.extended_position == '0)
  `SRW_ASSERT_IMP(a_newest_marked, anchored, seen_bitmap[0])
  `SRW_ASSERT_NEXT(a_anchor_after_item, advance, anchored && res_valid)

endmodule
